// ===== src/cdc_pkg.sv =====
// Shared types, constants and calendar helper functions for the calendar date counter.
package cdc_pkg;

  // Highest year the counter may hold, clipped to what the year field can carry.
  localparam int MAX_YEAR = 9999;
  localparam int YEAR_W = 14;
  localparam int YEAR_FIELD_MAX = (1 << YEAR_W) - 1;
  localparam logic [YEAR_W-1:0] TOP_YEAR =
    (MAX_YEAR > YEAR_FIELD_MAX) ? YEAR_W'(YEAR_FIELD_MAX) : YEAR_W'(MAX_YEAR);

  // Division by 25 and by 100 is done as a multiply by a scaled reciprocal.
  // Both are exact for every operand the 14-bit year can produce.
  localparam int RECIP_SHIFT = 19;
  localparam int RECIP_25 = 20972;
  localparam int RECIP_100 = 5243;

  // Operation codes carried in the mode field.
  localparam logic [1:0] MODE_NEXT = 2'd0;
  localparam logic [1:0] MODE_PREV = 2'd1;
  localparam logic [1:0] MODE_LOAD = 2'd2;

  // Status codes of a result.
  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_HOLD = 2'd2;

  localparam logic [3:0] MONTH_FIRST = 4'd1;
  localparam logic [3:0] MONTH_LAST = 4'd12;
  localparam logic [4:0] DAY_FIRST = 5'd1;
  localparam logic [4:0] DAY_LAST_DEC = 5'd31;

  typedef struct packed {
    logic [1:0]        mode;
    logic [4:0]        load_day;
    logic [3:0]        load_month;
    logic [YEAR_W-1:0] load_year;
  } in_item_t;

  typedef struct packed {
    logic [4:0]        day;
    logic [3:0]        month;
    logic [YEAR_W-1:0] year;
    logic [21:0]       day_number;
    logic [1:0]        status;
  } out_item_t;

  typedef struct packed {
    logic [4:0]        day;
    logic [3:0]        month;
    logic [YEAR_W-1:0] year;
  } date_t;

  // A stepped date together with its status, before the day number is known.
  typedef struct packed {
    date_t      date;
    logic [1:0] status;
  } stage_t;

  // A year is leap when divisible by 4, except centuries not divisible by 400.
  // Among multiples of 100, divisibility by 400 is the same as by 16.
  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [28:0]       prod;
    logic [9:0]        quot;
    logic [YEAR_W-1:0] back;
    prod = 29'(y) * 29'(RECIP_25);
    quot = 10'(prod >> RECIP_SHIFT);
    back = YEAR_W'(YEAR_W'(quot) * YEAR_W'(25));
    return (y[1:0] == 2'd0) && ((y[3:0] == 4'd0) || (back != y));
  endfunction

  // Length of a month; zero for a month code outside January to December.
  function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days of the year that lie before the first of month m.
  function automatic logic [8:0] days_before(input logic [3:0] m, input logic leap);
    logic [8:0] base;
    unique case (m)
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      default: base = 9'd0;
    endcase
    return base + ((leap && (m > 4'd2)) ? 9'd1 : 9'd0);
  endfunction

endpackage

// ===== src/cdc_date_step.sv =====
// Next-date logic: one day forward, one day back, a checked load, or the date kept for mode 3.
module cdc_date_step import cdc_pkg::*; (
  input  date_t      cur,
  input  in_item_t   item,
  output date_t      date_nxt,
  output logic [1:0] status_nxt
);

  logic       leap_cur;
  logic       leap_ld;
  logic [4:0] dim_cur;
  logic [4:0] dim_prev;
  logic [4:0] dim_ld;
  logic       load_ok;

  assign leap_cur = is_leap(cur.year);
  assign leap_ld  = is_leap(item.load_year);
  assign dim_cur  = days_in(cur.month, leap_cur);
  assign dim_prev = days_in(cur.month - 4'd1, leap_cur);
  assign dim_ld   = days_in(item.load_month, leap_ld);

  assign load_ok = (item.load_month >= MONTH_FIRST) && (item.load_month <= MONTH_LAST) &&
                   (item.load_year <= TOP_YEAR) && (item.load_day != 5'd0) &&
                   (item.load_day <= dim_ld);

  always_comb begin
    date_nxt   = cur;
    status_nxt = STATUS_OK;
    unique case (item.mode)
      MODE_NEXT: begin
        priority if (cur.day < dim_cur) begin
          date_nxt.day = cur.day + 5'd1;
        end else if (cur.month < MONTH_LAST) begin
          date_nxt.day   = DAY_FIRST;
          date_nxt.month = cur.month + 4'd1;
        end else if (cur.year < TOP_YEAR) begin
          date_nxt.day   = DAY_FIRST;
          date_nxt.month = MONTH_FIRST;
          date_nxt.year  = cur.year + YEAR_W'(1);
        end else begin
          status_nxt = STATUS_HOLD;
        end
      end
      MODE_PREV: begin
        priority if (cur.day > DAY_FIRST) begin
          date_nxt.day = cur.day - 5'd1;
        end else if (cur.month > MONTH_FIRST) begin
          date_nxt.month = cur.month - 4'd1;
          date_nxt.day   = dim_prev;
        end else if (cur.year != '0) begin
          date_nxt.year  = cur.year - YEAR_W'(1);
          date_nxt.month = MONTH_LAST;
          date_nxt.day   = DAY_LAST_DEC;
        end else begin
          status_nxt = STATUS_HOLD;
        end
      end
      MODE_LOAD: begin
        if (load_ok) begin
          date_nxt.day   = item.load_day;
          date_nxt.month = item.load_month;
          date_nxt.year  = item.load_year;
        end else begin
          status_nxt = STATUS_INVALID;
        end
      end
      default: begin
        date_nxt = cur;
      end
    endcase
  end

endmodule

// ===== src/cdc_day_number.sv =====
// Two-stage pipeline that attaches the day number to a stepped date.
module cdc_day_number import cdc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  stage_t    in_stage,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  typedef struct packed {
    stage_t      stage;
    logic [22:0] y365;
    logic [12:0] q4;
    logic [7:0]  q100;
    logic [7:0]  q400;
    logic [8:0]  doy;
  } part_t;

  logic        p_valid_r;
  part_t       p_r;
  part_t       p_nxt;
  logic        o_valid_r;
  out_item_t   o_r;
  out_item_t   o_nxt;
  logic        o_ready;
  logic [14:0] x4;
  logic [14:0] x100;
  logic [14:0] x400;
  logic [27:0] prod100;
  logic [27:0] prod400;
  logic        leap;
  logic [22:0] total;

  assign o_ready  = !o_valid_r || !out_stall;
  assign in_ready = !p_valid_r || o_ready;

  // First stage: the year times 365, the pieces of the leap-year count and the day of the year.
  assign x4      = {1'b0, in_stage.date.year} + 15'd3;
  assign x100    = {1'b0, in_stage.date.year} + 15'd99;
  assign x400    = {1'b0, in_stage.date.year} + 15'd399;
  assign prod100 = 28'(x100) * 28'(RECIP_100);
  assign prod400 = 28'(x400[14:2]) * 28'(RECIP_100);
  assign leap    = is_leap(in_stage.date.year);

  always_comb begin
    p_nxt.stage = in_stage;
    p_nxt.y365  = 23'(in_stage.date.year) * 23'd365;
    p_nxt.q4    = x4[14:2];
    p_nxt.q100  = prod100[26:19];
    p_nxt.q400  = prod400[26:19];
    p_nxt.doy   = days_before(in_stage.date.month, leap) + 9'(in_stage.date.day);
  end

  // Second stage: sum of the pieces.
  assign total = p_r.y365 + 23'(p_r.q4) + 23'(p_r.q400) + 23'(p_r.doy) - 23'(p_r.q100);

  always_comb begin
    o_nxt.day        = p_r.stage.date.day;
    o_nxt.month      = p_r.stage.date.month;
    o_nxt.year       = p_r.stage.date.year;
    o_nxt.day_number = total[21:0];
    o_nxt.status     = p_r.stage.status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        p_valid_r <= in_valid;
      end
      if (o_ready) begin
        o_valid_r <= p_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      p_r <= p_nxt;
    end
    if (o_ready && p_valid_r) begin
      o_r <= o_nxt;
    end
  end

  assign out_valid = o_valid_r;
  assign out_item  = o_r;

endmodule

// ===== src/calendar_date_counter.sv =====
// Top level of the calendar date counter: date state, input stage and result pipeline.
//
// The counter holds one Gregorian date (day, month, year from 0 to TOP_YEAR) that
// starts at 1 January of year 0 after reset. Each input transaction steps the date
// one day forward, one day back, or loads a new date; every transaction yields
// exactly one result transaction carrying the date after the step, its day number
// (365 days per earlier year plus the leap days of earlier years plus the day of
// the current year, counting year 0 as leap) and a status. A load that names an
// impossible date is refused with the invalid status and the date is kept; a step
// beyond 31 December of TOP_YEAR or before 1 January of year 0 keeps the date and
// reports the hold status; mode 3 keeps the date with status ok. One transaction
// is accepted per clock cycle while in_stall is low. Its result passes through the
// input stage, the first day number stage and the result register before it is
// shown on the output. The loop through the date registers and the next-date
// logic sets the rate; the day number is worked out over the two following pipeline
// stages. The pipeline holds up to three transactions, so a stalled result does
// not stop input until those stages have filled.
module calendar_date_counter import cdc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  // Current date. It changes as soon as a transaction is accepted, so the next
  // transaction in the following cycle already sees the stepped date.
  date_t      cur_r;
  date_t      cur_nxt;
  logic [1:0] status_nxt;

  // Input stage: the stepped date and status waiting for the day number pipeline.
  logic       s1_valid_r;
  logic       s1_valid_nxt;
  stage_t     s1_r;
  logic       dn_ready;
  logic       accept;

  cdc_date_step u_step (
    .cur        (cur_r),
    .item       (in_item),
    .date_nxt   (cur_nxt),
    .status_nxt (status_nxt)
  );

  // The input stage frees up whenever the day number pipeline takes its contents.
  assign in_stall = s1_valid_r && !dn_ready;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (dn_ready) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r.day   <= DAY_FIRST;
      cur_r.month <= MONTH_FIRST;
      cur_r.year  <= '0;
      s1_valid_r  <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (accept) begin
        cur_r <= cur_nxt;
      end
    end
  end

  // The payload of the input stage needs no reset; its valid bit guards it.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r.date   <= cur_nxt;
      s1_r.status <= status_nxt;
    end
  end

  // Day number stages, the second of which is the result register. A stalled result
  // holds it there, and the stages behind it take input only until they are full.
  cdc_day_number u_day_number (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid_r),
    .in_ready  (dn_ready),
    .in_stage  (s1_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ===== src/cdc_checker.sv =====
// Port-level assertions for the calendar date counter and the bind that attaches them.
module cdc_checker import cdc_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  // A held result must stay on the port until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed or dropped while stalled");

  // Input backpressure only arises from a full pipeline behind a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // Every reported date has a nonzero day, a month from January to December and a year within range.
  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.day != 5'd0) && (out_item.month >= MONTH_FIRST) &&
                  (out_item.month <= MONTH_LAST) && (out_item.year <= TOP_YEAR))
    else $error("result date out of range");

  // A range hold can only happen at one of the two ends of the calendar.
  a_hold_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == STATUS_HOLD) |->
      ((out_item.day == DAY_LAST_DEC) && (out_item.month == MONTH_LAST) &&
       (out_item.year == TOP_YEAR)) ||
      ((out_item.day == DAY_FIRST) && (out_item.month == MONTH_FIRST) &&
       (out_item.year == '0)))
    else $error("range hold reported away from the calendar ends");

endmodule

bind calendar_date_counter cdc_checker u_cdc_checker (.*);

// ===== bench/calendar_date_checker.sv =====
// Checker for the calendar date counter: tracks the date, predicts each result, compares it.
module calendar_date_checker import cdc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_item,
  output int        pending,
  output int        errors
);
  timeunit 1ns;
  timeprecision 1ps;

  date_t     held;
  out_item_t expected_dates[$];
  out_item_t want;

  function automatic bit leap_year(int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned month_days(int unsigned m, int unsigned y);
    if (m < 1 || m > 12) return 0;
    case (m)
      2:           return leap_year(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  // Days in all earlier years, year 0 being leap, plus the day of this year.
  function automatic logic [21:0] ordinal_day(date_t d);
    int unsigned y;
    int unsigned n;
    y = d.year;
    n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    for (int unsigned m = 1; m < d.month; m++) n += month_days(m, y);
    n += d.day;
    return n[21:0];
  endfunction

  // Applies one transaction to the held date and returns the result it should produce.
  function automatic out_item_t step_calendar(in_item_t it);
    logic [1:0] st;
    out_item_t  r;
    st = STATUS_OK;
    case (it.mode)
      MODE_NEXT: begin
        if (held.day < month_days(held.month, held.year)) begin
          held.day = held.day + 1'b1;
        end else if (held.month < MONTH_LAST) begin
          held.day = DAY_FIRST;
          held.month = held.month + 1'b1;
        end else if (held.year < TOP_YEAR) begin
          held.day = DAY_FIRST;
          held.month = MONTH_FIRST;
          held.year = held.year + 1'b1;
        end else begin
          st = STATUS_HOLD;
        end
      end
      MODE_PREV: begin
        if (held.day > DAY_FIRST) begin
          held.day = held.day - 1'b1;
        end else if (held.month > MONTH_FIRST) begin
          held.month = held.month - 1'b1;
          held.day = 5'(month_days(held.month, held.year));
        end else if (held.year > 0) begin
          held.year = held.year - 1'b1;
          held.month = MONTH_LAST;
          held.day = DAY_LAST_DEC;
        end else begin
          st = STATUS_HOLD;
        end
      end
      MODE_LOAD: begin
        if (it.load_month < MONTH_FIRST || it.load_month > MONTH_LAST ||
            it.load_year > TOP_YEAR || it.load_day < DAY_FIRST ||
            it.load_day > month_days(it.load_month, it.load_year)) begin
          st = STATUS_INVALID;
        end else begin
          held.day = it.load_day;
          held.month = it.load_month;
          held.year = it.load_year;
        end
      end
      default: ;
    endcase
    r.day = held.day;
    r.month = held.month;
    r.year = held.year;
    r.day_number = ordinal_day(held);
    r.status = st;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
    $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, exp_val);
    errors++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] exp_val);
    if (got !== exp_val) report_mismatch({"wrong ", name}, got, exp_val);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      held = '{day: DAY_FIRST, month: MONTH_FIRST, year: '0};
      expected_dates.delete();
      pending <= 0;
    end else begin
      if (in_valid && !in_stall) expected_dates.push_back(step_calendar(in_item));
      if (out_valid && !out_stall) begin
        if (expected_dates.size() == 0) begin
          report_mismatch("result transaction with nothing pending", out_item.day_number, 0);
        end else begin
          want = expected_dates.pop_front();
          check_field("day", out_item.day, want.day);
          check_field("month", out_item.month, want.month);
          check_field("year", out_item.year, want.year);
          check_field("day_number", out_item.day_number, want.day_number);
          check_field("status", out_item.status, want.status);
        end
      end
      pending <= expected_dates.size();
    end
  end

endmodule

// ===== bench/tb.sv =====
// Testbench top for the calendar date counter: stimulus, idling on both channels, verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cdc_pkg::*;

  // The mode field has one code the block leaves unused; it must keep the date.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // The random part stops once this many transactions have been accepted.
  localparam int unsigned RANDOM_ITEMS = 480;
  // Over the last stretch of the random part neither side idles.
  localparam int unsigned QUIET_TAIL = 80;
  // Length of the one long receiver hold, far beyond the three-deep pipeline.
  localparam int unsigned LONG_HOLD = 120;
  // Extra cycles waited after the final drain, to catch any stray result.
  localparam int unsigned DRAIN_CYCLES = 8;
  // The slowest legal run is around 600 transactions, slowed by sender pauses,
  // receiver stall bursts and the long hold, and it stays far below this limit.
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  int          pending;
  int          errors;
  int unsigned cycles = 0;
  int unsigned sent = 0;
  // Sender idles before roughly one transaction in gap_odds; zero turns idling off.
  int unsigned gap_odds = 4;
  // Control flags for the receiver. They are written with nonblocking assignments,
  // so the receiver cannot see them before the next edge, no matter how the processes are ordered.
  bit          quiet = 1'b0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;

  calendar_date_counter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  calendar_date_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .pending  (pending),
    .errors   (errors)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog. A lost result keeps the checker's pending count above zero, and the
  // final drain then never finishes, so this is also how a missing result fails.
  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  // Receiver side. Each pass picks one value for out_stall and holds it for a span
  // of cycles, so the signal gets at most one assignment per edge. Random stall
  // bursts mix with free-running stretches; on request it holds one long stall
  // while the sender keeps offering, which fills the pipeline and must push the
  // stall back to the input channel.
  initial begin : receiver
    int unsigned span;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req != hold_seen) begin
        hold_seen++;
        out_stall <= 1'b1;
        span = LONG_HOLD;
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        span = $urandom_range(1, 15);
      end else begin
        out_stall <= 1'b0;
        span = quiet ? 1 : $urandom_range(1, 20);
      end
      repeat (span) @(posedge clk);
    end
  end

  // Offers one transaction and returns at the edge that accepts it. The payload
  // stays put while the block stalls, and valid stays high into the next call.
  task automatic offer(in_item_t it);
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic pause(int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_one(in_item_t it);
    offer(it);
    sent++;
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) pause($urandom_range(1, 15));
  endtask

  // Lowers valid and waits until every result predicted so far has come back. The
  // checker registers its count, hence the edge before the first look.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic in_item_t load_item(int unsigned d, int unsigned m, int unsigned y);
    in_item_t it;
    it.mode = MODE_LOAD;
    it.load_day = 5'(d);
    it.load_month = 4'(m);
    it.load_year = YEAR_W'(y);
    return it;
  endfunction

  // A step or unused-mode transaction whose load fields carry random noise, which
  // the block has to ignore.
  function automatic in_item_t step_item(logic [1:0] mode);
    in_item_t it;
    it = in_item_t'(25'($urandom));
    it.mode = mode;
    return it;
  endfunction

  // Years are drawn mostly where the calendar has edges: the very first years,
  // the last ones allowed, century years and their neighbors, and leap years.
  function automatic int unsigned pick_year();
    int unsigned top;
    top = TOP_YEAR;
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 4);
      1:       return top - $urandom_range(0, 3);
      2:       return 100 * $urandom_range(1, top / 100) - $urandom_range(0, 1);
      3:       return 4 * $urandom_range(0, top / 4);
      default: return $urandom_range(0, top);
    endcase
  endfunction

  // Loads land mostly on the first or last days of a month so that the steps that
  // follow cross month and year ends. Days 29 to 31 are often too long for the
  // month, which gives a steady share of refused loads.
  function automatic in_item_t random_load();
    int unsigned d;
    case ($urandom_range(0, 4))
      0:       d = 1;
      1:       d = 28;
      2:       d = $urandom_range(29, 31);
      default: d = $urandom_range(1, 28);
    endcase
    return load_item(d, $urandom_range(1, 12), pick_year());
  endfunction

  initial begin : stimulus
    in_item_t    plan[$];
    in_item_t    it;
    int unsigned run;
    logic [1:0]  dir;
    logic [1:0]  back;
    bit          held_once;
    bit          drained_once;

    held_once = 1'b0;
    drained_once = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. From the reset date it steps forward and back to 1 January of
    // year 0, tries to go below it and sends the unused mode. It then loads the last
    // day allowed and tries to step past it, checks leap days in a year divisible by
    // 400, in a plain century and in an ordinary leap year, crosses a leap day, a
    // century's end of February and a year end in both directions, and finally tries
    // loads with a zero day, a day too long for the month, month codes out of range,
    // the first year above the top and the all-ones pattern in every load field.
    plan = '{
      step_item(MODE_NEXT), step_item(MODE_PREV), step_item(MODE_PREV),
      step_item(MODE_UNUSED),
      load_item(31, 12, TOP_YEAR), step_item(MODE_NEXT), step_item(MODE_PREV),
      step_item(MODE_NEXT),
      load_item(29, 2, 2000), load_item(29, 2, 1900), load_item(29, 2, 2024),
      step_item(MODE_NEXT), step_item(MODE_PREV),
      load_item(1, 3, 2100), step_item(MODE_PREV),
      load_item(31, 12, 1999), step_item(MODE_NEXT), step_item(MODE_PREV),
      load_item(0, 5, 100), load_item(31, 4, 400), load_item(1, 0, 50),
      load_item(1, 13, 50), load_item(31, 15, 50), load_item(1, 1, TOP_YEAR + 1),
      load_item(31, 15, 16383)
    };
    foreach (plan[i]) send_one(plan[i]);
    drain();
    sent = 0;

    // Random part, in episodes: a load (sometimes raw noise, sometimes the unused
    // mode) followed by a run of steps that mostly keeps one direction, so that runs
    // started near a month end walk across it and runs near the range ends hit the
    // hold. The sender's idling rate changes now and then, including stretches
    // with no idling at all.
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0:       gap_odds = 0;
          1:       gap_odds = 2;
          2:       gap_odds = 4;
          default: gap_odds = 8;
        endcase
      end

      if (!held_once && sent >= 150) begin
        // Long receiver hold while the sender keeps offering back to back.
        held_once = 1'b1;
        hold_req <= hold_req + 1;
        gap_odds = 0;
      end
      if (!drained_once && sent >= 300) begin
        // The sender stops until the pipeline has delivered everything.
        drained_once = 1'b1;
        drain();
      end
      if (sent + QUIET_TAIL >= RANDOM_ITEMS) begin
        quiet <= 1'b1;
        gap_odds = 0;
      end

      case ($urandom_range(0, 9))
        0: begin
          it = in_item_t'(25'($urandom));
          it.mode = MODE_LOAD;
        end
        1:       it = step_item(MODE_UNUSED);
        default: it = random_load();
      endcase
      send_one(it);

      run = $urandom_range(0, 30);
      dir = $urandom_range(0, 1) ? MODE_PREV : MODE_NEXT;
      back = (dir == MODE_NEXT) ? MODE_PREV : MODE_NEXT;
      repeat (run) send_one(step_item(($urandom_range(0, 9) == 0) ? back : dir));
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== calendar_date_counter.f =====
src/cdc_pkg.sv
src/cdc_date_step.sv
src/cdc_day_number.sv
src/calendar_date_counter.sv
src/cdc_checker.sv
bench/calendar_date_checker.sv
bench/tb.sv
